/* hw/rtl/assert_macros.svh */
// concurrent assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is high
`define SBQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbq assertion failed");

// same edge implication
`define SBQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   `SBQ_ASSERT(label, clk, rst, (ante) |-> (cons))

// next edge implication
`define SBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   `SBQ_ASSERT(label, clk, rst, (ante) |=> (cons))

`endif

/* hw/rtl/sbq_pkg.sv */
`timescale 1ns / 1ps

package sbq_pkg;

   localparam int COEF_BITS      = 24;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FEEDFORWARD_0 = 3'd0,
      CSR_FEEDFORWARD_1 = 3'd1,
      CSR_FEEDFORWARD_2 = 3'd2,
      CSR_FEEDBACK_1    = 3'd3,
      CSR_FEEDBACK_2    = 3'd4
   } csr_index_type;

   typedef enum logic {
      ACTION_FILTER = 1'b0,
      ACTION_CLEAR  = 1'b1
   } action_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] feedforward_0;
      logic signed [COEF_BITS-1:0] feedforward_1;
      logic signed [COEF_BITS-1:0] feedforward_2;
      logic signed [COEF_BITS-1:0] feedback_1;
      logic signed [COEF_BITS-1:0] feedback_2;
   } coef_set_type;

   localparam coef_set_type COEF_RESET = '{
      feedforward_0: 24'sd2097152,
      feedforward_1: 24'sd0,
      feedforward_2: 24'sd0,
      feedback_1:    24'sd0,
      feedback_2:    24'sd0
   };

endpackage

/* hw/rtl/sbq_if.sv */
`timescale 1ns / 1ps

interface sbq_req_if
   import sbq_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, action, left_sample, right_sample, input ready);
   modport sink   (input valid, action, left_sample, right_sample, output ready);
endinterface

interface sbq_rsp_if
   import sbq_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_result;
   logic signed [SAMPLE_BITS-1:0] right_result;

   modport source (output valid, left_result, right_result, input ready);
   modport sink   (input valid, left_result, right_result, output ready);
endinterface

interface sbq_csr_if
   import sbq_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [COEF_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/stereo_biquad_iir_filter_top.sv */
`timescale 1ns / 1ps

// Stereo direct form I biquad: each request transaction carries a left and a right
// sample, filtered with the five shared coefficients (Q3.21) into a rounded, saturated
// response. One transaction is accepted every cycle while responses are taken. A request
// is registered in the stage registers and its response in the output registers once the
// output is free. The multiply-accumulate of both channels is combinational between them,
// and its outputs feed back into the next sample's history. A response held by rsp_ch.ready
// low lets clear requests through and one more filter request in, then stalls the request
// side. A clear transaction zeroes all histories and returns no response. Coefficient writes
// are accepted at any time but must only be issued while the filter is idle.
module stereo_biquad_iir_filter_top
   import sbq_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 21
)(
   input logic       clock,
   input logic       reset,
   sbq_req_if.sink   req_ch,
   sbq_rsp_if.source rsp_ch,
   sbq_csr_if.sink   csr_ch
);

   coef_set_type                  coefs;
   logic                          stage_valid_ff, stage_valid_in;
   logic                          stage_action_ff;
   logic signed [SAMPLE_BITS-1:0] stage_left_ff, stage_right_ff;
   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_right_ff;
   logic signed [SAMPLE_BITS-1:0] left_y, right_y;
   logic                          out_free;
   logic                          stage_fire;
   logic                          filter_fire;
   logic                          clear_fire;
   logic                          req_fire;

   sbq_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .coefs  (coefs)
   );

   assign out_free    = !out_valid_ff || rsp_ch.ready;
   assign stage_fire  = stage_valid_ff && ((stage_action_ff == ACTION_CLEAR) || out_free);
   assign filter_fire = stage_fire && (stage_action_ff == ACTION_FILTER);
   assign clear_fire  = stage_fire && (stage_action_ff == ACTION_CLEAR);
   assign req_fire    = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !stage_valid_ff || stage_fire;

   sbq_channel #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_left (
      .clock   (clock),
      .reset   (reset),
      .coefs   (coefs),
      .advance (filter_fire),
      .clear   (clear_fire),
      .sample  (stage_left_ff),
      .result  (left_y)
   );

   sbq_channel #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_right (
      .clock   (clock),
      .reset   (reset),
      .coefs   (coefs),
      .advance (filter_fire),
      .clear   (clear_fire),
      .sample  (stage_right_ff),
      .result  (right_y)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (filter_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_action_ff <= req_ch.action;
         stage_left_ff   <= req_ch.left_sample;
         stage_right_ff  <= req_ch.right_sample;
      end
      if (filter_fire) begin
         out_left_ff  <= left_y;
         out_right_ff <= right_y;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.left_result  = out_left_ff;
   assign rsp_ch.right_result = out_right_ff;

endmodule

/* hw/rtl/sbq_csr.sv */
`timescale 1ns / 1ps

module sbq_csr
   import sbq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   sbq_csr_if.sink      csr_ch,
   output coef_set_type coefs
);

   coef_set_type coef_ff;
   coef_set_type coef_in;

   assign csr_ch.ready = 1'b1;
   assign coefs        = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FEEDFORWARD_0: coef_in.feedforward_0 = $signed(csr_ch.data);
            CSR_FEEDFORWARD_1: coef_in.feedforward_1 = $signed(csr_ch.data);
            CSR_FEEDFORWARD_2: coef_in.feedforward_2 = $signed(csr_ch.data);
            CSR_FEEDBACK_1:    coef_in.feedback_1    = $signed(csr_ch.data);
            CSR_FEEDBACK_2:    coef_in.feedback_2    = $signed(csr_ch.data);
            default:           coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

/* hw/rtl/sbq_channel.sv */
`timescale 1ns / 1ps

module sbq_channel
   import sbq_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 21
)(
   input  logic                          clock,
   input  logic                          reset,
   input  coef_set_type                  coefs,
   input  logic                          advance,
   input  logic                          clear,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int ProdW = SAMPLE_BITS + COEF_BITS;
   localparam int AccW  = ProdW + 3;
   localparam logic signed [AccW-1:0] RoundBias = AccW'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [AccW-1:0] SatHi = AccW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [AccW-1:0] SatLo = AccW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   logic signed [SAMPLE_BITS-1:0] in1_ff, in2_ff, out1_ff, out2_ff;
   logic signed [SAMPLE_BITS-1:0] in1_in, in2_in, out1_in, out2_in;
   logic signed [ProdW-1:0]       prod0, prod1, prod2, prod3, prod4;
   logic signed [AccW-1:0]        acc;
   logic signed [AccW-1:0]        rounded;

   assign prod0 = coefs.feedforward_0 * sample;
   assign prod1 = coefs.feedforward_1 * in1_ff;
   assign prod2 = coefs.feedforward_2 * in2_ff;
   assign prod3 = coefs.feedback_1    * out1_ff;
   assign prod4 = coefs.feedback_2    * out2_ff;

   assign acc = AccW'(prod0) + AccW'(prod1) + AccW'(prod2) - AccW'(prod3) - AccW'(prod4);
   assign rounded = (acc + RoundBias) >>> COEF_FRAC_BITS;

   always_comb begin
      if (rounded > SatHi) begin
         result = SatHi[SAMPLE_BITS-1:0];
      end else if (rounded < SatLo) begin
         result = SatLo[SAMPLE_BITS-1:0];
      end else begin
         result = rounded[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      in1_in  = in1_ff;
      in2_in  = in2_ff;
      out1_in = out1_ff;
      out2_in = out2_ff;
      if (clear) begin
         in1_in  = '0;
         in2_in  = '0;
         out1_in = '0;
         out2_in = '0;
      end else if (advance) begin
         in1_in  = sample;
         in2_in  = in1_ff;
         out1_in = result;
         out2_in = out1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in1_ff  <= '0;
         in2_ff  <= '0;
         out1_ff <= '0;
         out2_ff <= '0;
      end else begin
         in1_ff  <= in1_in;
         in2_ff  <= in2_in;
         out1_ff <= out1_in;
         out2_ff <= out2_in;
      end
   end

endmodule

/* hw/rtl/sbq_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbq_checker #(
   parameter int SAMPLE_BITS = 24
)(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_left,
   input logic [SAMPLE_BITS-1:0] rsp_right,
   input logic                   csr_ready
);

   `SBQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_left) && $stable(rsp_right))
   `SBQ_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `SBQ_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), req_ready && !rsp_valid)
   `SBQ_ASSERT(a_csr_ready, clock, reset, csr_ready)

endmodule

bind stereo_biquad_iir_filter_top sbq_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_sbq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_left  (rsp_ch.left_result),
   .rsp_right (rsp_ch.right_result),
   .csr_ready (csr_ch.ready)
);
